@@ sv/bup_pkg.sv @@
// bup_pkg: shared types, constants and helpers of the 2x bilinear upscaler
// no dependencies
package bup_pkg;

    localparam int CH_W           = 8;
    localparam int N_CHAN         = 3;
    localparam int PIX_W          = CH_W * N_CHAN;
    localparam int COORD_W        = 12;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 1;
    localparam int OUT_W          = 2 * COORD_W + PIX_W;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [CH_W-1:0]  chan_t;

    // position inside one 2x2 output block
    typedef enum logic [1:0] {
        SUB_TL = 2'd0,
        SUB_TR = 2'd1,
        SUB_BL = 2'd2,
        SUB_BR = 2'd3
    } sub_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } out_ctl_t;

    // last valid index for a size register: zero acts as one, large values clamp
    function automatic int dim_last(logic [CFG_W-1:0] v, int maxv);
        int vi;
        vi = int'(v);
        if (vi == 0)
            return 0;
        if (vi > maxv)
            return maxv - 1;
        return vi - 1;
    endfunction

endpackage

@@ sv/bilinear_upscale_2x_rgb_top.sv @@
// bilinear_upscale_2x_rgb_top: 2x bilinear upscaler, line buffer, block sequencer, lanes
// depends on bup_pkg, bup_ram, bup_lane, bup_merge
//
// usage:
//   s_* takes one source pixel per word in raster order, blue in the low byte.
//   m_* gives output pixels with their doubled-image coordinates; m_tlast marks
//   the last word caused by one source pixel. each pixel closes 0, 1, 2 or 4
//   2x2 blocks (0, 4, 8 or 16 words); output trails input by one row and column.
//   cfg_we/cfg_index/cfg_data write width (index 0) and height (index 1) while idle.
//   path: a taken pixel waits in the block stage registers, and each of its words
//   then passes the single output register. throughput: one output word per cycle
//   while m_tready is high; the words of a pixel leave in block emission order,
//   and a new pixel is taken in the cycle its predecessor hands over its last
//   word.
//   reset: counters return to the frame start, size returns to 640x480; the
//   line buffer is not cleared (each entry is used only after it is written).
//   a stalled receiver holds the output word and, once the block in hand is
//   waiting, holds off s_tready.
module bilinear_upscale_2x_rgb_top #(
    parameter int MAX_WIDTH  = bup_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bup_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bup_pkg::PIX_W-1:0]     s_tdata,   // in_blue, in_green, in_red
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bup_pkg::OUT_W-1:0]     m_tdata,   // out_x, out_y, out_blue, out_green, out_red
    output logic                          m_tlast,   // run_last
    input  logic                          cfg_we,
    input  logic [bup_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bup_pkg::CFG_W-1:0]     cfg_data
);
    import bup_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // one-hot block codes, in emission order
    localparam logic [3:0] BLK_DIAG  = 4'b0001;
    localparam logic [3:0] BLK_RIGHT = 4'b0010;
    localparam logic [3:0] BLK_BELOW = 4'b0100;
    localparam logic [3:0] BLK_LAST  = 4'b1000;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_last_reg;
    logic [RW-1:0] row_last_reg;
    pix_t          left_reg;

    logic          s1_valid_reg;
    logic [3:0]    s1_mask_reg;
    sub_t          s1_sub_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    pix_t          s1_p_reg;
    pix_t          s1_left_reg;
    pix_t          s1_ul_reg;

    pix_t          ram_rd;
    logic          accept;
    logic          last_col;
    logic          last_row;
    logic [3:0]    new_mask;
    logic [3:0]    cur_blk;
    logic          fire;
    logic          room;
    logic          retire;
    logic          final_word;
    pix_t          e1;
    pix_t          e2;
    pix_t          e3;
    pix_t          e4;
    logic [CW-1:0] bx;
    logic [RW-1:0] by;
    out_ctl_t      out_ctl;
    logic [N_CHAN-1:0][CH_W-1:0] lane_val;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= CW'(dim_last(CFG_W'(RESET_WIDTH), MAX_WIDTH));
            row_last_reg <= RW'(dim_last(CFG_W'(RESET_HEIGHT), MAX_HEIGHT));
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  col_last_reg <= CW'(dim_last(cfg_data, MAX_WIDTH));
                REG_HEIGHT: row_last_reg <= RW'(dim_last(cfg_data, MAX_HEIGHT));
                default:    col_last_reg <= col_last_reg;
            endcase
        end
    end

    // input stage
    assign accept   = s_tvalid && s_tready;
    assign last_col = col_reg >= col_last_reg;
    assign last_row = row_reg >= row_last_reg;
    assign new_mask = {last_row && last_col, last_row && (col_reg != '0),
                       (row_reg != '0) && last_col, (row_reg != '0) && (col_reg != '0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    bup_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (accept),
        .re    (accept),
        .addr  (col_reg),
        .wdata (s_tdata),
        .rdata (ram_rd)
    );

    // block sequencer
    assign cur_blk    = s1_mask_reg & (~s1_mask_reg + 4'd1);
    assign fire       = s1_valid_reg && (cur_blk != 4'd0) && room;
    assign final_word = (s1_sub_reg == SUB_BR) && ((s1_mask_reg & ~cur_blk) == 4'd0);
    assign retire     = s1_valid_reg && ((s1_mask_reg == 4'd0) || (fire && final_word));
    assign s_tready   = !s1_valid_reg || retire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_mask_reg  <= 4'd0;
            s1_sub_reg   <= SUB_TL;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_mask_reg  <= new_mask;
            s1_sub_reg   <= SUB_TL;
        end
        else
        begin
            if (retire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                s1_sub_reg <= sub_t'(s1_sub_reg + 2'd1);
                if (s1_sub_reg == SUB_BR)
                begin
                    s1_mask_reg <= s1_mask_reg & ~cur_blk;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg    <= s_tdata;
            s1_p_reg    <= s_tdata;
            s1_left_reg <= left_reg;
            s1_ul_reg   <= ram_rd;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
        end
    end

    // corner pixels of the current block
    always_comb
    begin
        unique case (cur_blk)
            BLK_DIAG:
            begin
                e1 = s1_ul_reg;   e2 = ram_rd;   e3 = s1_left_reg; e4 = s1_p_reg;
                bx = s1_col_reg - 1'b1;
                by = s1_row_reg - 1'b1;
            end
            BLK_RIGHT:
            begin
                e1 = ram_rd;      e2 = ram_rd;   e3 = s1_p_reg;    e4 = s1_p_reg;
                bx = s1_col_reg;
                by = s1_row_reg - 1'b1;
            end
            BLK_BELOW:
            begin
                e1 = s1_left_reg; e2 = s1_p_reg; e3 = s1_left_reg; e4 = s1_p_reg;
                bx = s1_col_reg - 1'b1;
                by = s1_row_reg;
            end
            default:
            begin
                e1 = s1_p_reg;    e2 = s1_p_reg; e3 = s1_p_reg;    e4 = s1_p_reg;
                bx = s1_col_reg;
                by = s1_row_reg;
            end
        endcase
    end

    assign out_ctl.x    = COORD_W'({bx, s1_sub_reg[0]});
    assign out_ctl.y    = COORD_W'({by, s1_sub_reg[1]});
    assign out_ctl.last = final_word;

    // channel lanes
    for (genvar k = 0; k < N_CHAN; k++)
    begin : g_lane
        bup_lane u_lane (
            .a   (e1[k*CH_W +: CH_W]),
            .b   (e2[k*CH_W +: CH_W]),
            .c   (e3[k*CH_W +: CH_W]),
            .d   (e4[k*CH_W +: CH_W]),
            .sub (s1_sub_reg),
            .val (lane_val[k])
        );
    end

    bup_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .ctl      (out_ctl),
        .chan     (lane_val),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with empty block stage");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg && (s1_sub_reg == SUB_TL))
        else $error("new pixel did not start at first block position");

    a_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_sub_reg != SUB_TL)) |-> (s1_mask_reg != 4'd0))
        else $error("block in progress with no block pending");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && final_word) |=> (!s1_valid_reg || $past(accept)))
        else $error("block stage busy after final word");

endmodule

@@ sv/bup_ram.sv @@
// bup_ram: generic single-port ram, registered read, old data on read-during-write
// no dependencies
module bup_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/bup_lane.sv @@
// bup_lane: one color channel of an output pixel, a corner or a truncated mean of the corners
// depends on bup_pkg
module bup_lane (
    input  bup_pkg::chan_t a,
    input  bup_pkg::chan_t b,
    input  bup_pkg::chan_t c,
    input  bup_pkg::chan_t d,
    input  bup_pkg::sub_t  sub,
    output bup_pkg::chan_t val
);
    import bup_pkg::*;

    logic [CH_W:0]   sum_ab;
    logic [CH_W:0]   sum_ac;
    logic [CH_W:0]   sum_cd;
    logic [CH_W+1:0] sum_all;

    assign sum_ab  = {1'b0, a} + {1'b0, b};
    assign sum_ac  = {1'b0, a} + {1'b0, c};
    assign sum_cd  = {1'b0, c} + {1'b0, d};
    assign sum_all = {1'b0, sum_ab} + {1'b0, sum_cd};

    always_comb
    begin
        unique case (sub)
            SUB_TL:  val = a;
            SUB_TR:  val = sum_ab[CH_W:1];
            SUB_BL:  val = sum_ac[CH_W:1];
            SUB_BR:  val = sum_all[CH_W+1:2];
            default: val = a;
        endcase
    end

endmodule

@@ sv/bup_merge.sv @@
// bup_merge: output register that packs coordinates and lane results into one word
// depends on bup_pkg
module bup_merge (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          load,
    input  bup_pkg::out_ctl_t                             ctl,
    input  logic [bup_pkg::N_CHAN-1:0][bup_pkg::CH_W-1:0] chan,
    output logic                                          room,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [bup_pkg::OUT_W-1:0]                     m_tdata,  // x, y, blue, green, red
    output logic                                          m_tlast
);
    import bup_pkg::*;

    logic             valid_reg;
    logic [OUT_W-1:0] data_reg;
    logic             last_reg;

    assign room = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && room)
        begin
            data_reg <= {chan, ctl.y, ctl.x};
            last_reg <= ctl.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule
